[design/fpca_pkg.sv]
// ----------------------------------------------------------------------------
// fpca_pkg: shared types and constants of the fit-policy cell allocator
// Field widths, status and policy codes, request kinds, and the per-cell
// step record passed from the scan sequencer to the run picker.
// ----------------------------------------------------------------------------
package fpca_pkg;

  localparam int unsigned TypeW   = 1;
  localparam int unsigned OwnerW  = 16;
  localparam int unsigned SizeW   = 11;
  localparam int unsigned StatusW = 2;
  localparam int unsigned StartW  = 10;
  localparam int unsigned FreedW  = 11;
  localparam int unsigned PolicyW = 2;

  localparam logic [StatusW-1:0] STATUS_DONE    = 2'd0;
  localparam logic [StatusW-1:0] STATUS_NOFIT   = 2'd1;
  localparam logic [StatusW-1:0] STATUS_INVALID = 2'd2;

  localparam logic [PolicyW-1:0] POLICY_FIRST = 2'd0;
  localparam logic [PolicyW-1:0] POLICY_BEST  = 2'd1;
  localparam logic [PolicyW-1:0] POLICY_WORST = 2'd2;

  localparam logic [TypeW-1:0] REQ_ALLOC = 1'b0;
  localparam logic [TypeW-1:0] REQ_CLEAR = 1'b1;

  // One scanned cell as seen by the run picker.
  typedef struct packed {
    logic clr;   // start of a new scan
    logic vld;   // a cell (or the end marker) is presented
    logic free;  // cell is free; low on the end marker
  } step_t;

endpackage

[design/fpca_map_ram.sv]
// ----------------------------------------------------------------------------
// fpca_map_ram: cell owner map
// Simple dual-port memory, one write and one read port, read data registered.
// ----------------------------------------------------------------------------
module fpca_map_ram #(
  parameter int unsigned Depth = 1024,
  parameter int unsigned AddrW = 10,
  parameter int unsigned DataW = 16
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [DataW-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [DataW-1:0] rdata_o
);

  logic [DataW-1:0] mem_q [Depth];
  logic [DataW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[design/fpca_run_pick.sv]
// ----------------------------------------------------------------------------
// fpca_run_pick: free-run tracker and policy selection
// Follows the free runs cell by cell and keeps the run chosen by the
// placement policy. Ties stay with the earliest run.
// ----------------------------------------------------------------------------
module fpca_run_pick #(
  parameter int unsigned AddrW  = 10,
  parameter int unsigned CountW = 11
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  fpca_pkg::step_t               step_i,
  input  logic [CountW-1:0]             idx_i,
  input  logic [CountW-1:0]             need_i,
  input  logic [fpca_pkg::PolicyW-1:0]  policy_i,
  output logic                          found_o,
  output logic [AddrW-1:0]              best_start_o
);

  logic              found_q, found_d;
  logic [AddrW-1:0]  run_start_q, run_start_d;
  logic [AddrW-1:0]  best_start_q, best_start_d;
  logic [CountW-1:0] run_len_q, run_len_d;
  logic [CountW-1:0] best_len_q, best_len_d;
  logic              take;

  always_comb begin
    found_d      = found_q;
    run_start_d  = run_start_q;
    best_start_d = best_start_q;
    run_len_d    = run_len_q;
    best_len_d   = best_len_q;
    take         = 1'b0;
    if (step_i.clr) begin
      found_d      = 1'b0;
      run_start_d  = '0;
      best_start_d = '0;
      run_len_d    = '0;
      best_len_d   = '0;
    end else if (step_i.vld) begin
      if (step_i.free) begin
        if (run_len_q == '0) begin
          run_start_d = idx_i[AddrW-1:0];
        end
        run_len_d = run_len_q + CountW'(1);
      end else begin
        // close the current run and judge it
        if (run_len_q >= need_i) begin
          unique case (policy_i)
            fpca_pkg::POLICY_BEST:  take = !found_q || (run_len_q < best_len_q);
            fpca_pkg::POLICY_WORST: take = !found_q || (run_len_q > best_len_q);
            default:                take = !found_q;
          endcase
        end
        if (take) begin
          found_d      = 1'b1;
          best_start_d = run_start_q;
          best_len_d   = run_len_q;
        end
        run_len_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q   <= 1'b0;
      run_len_q <= '0;
    end else begin
      found_q   <= found_d;
      run_len_q <= run_len_d;
    end
  end

  always_ff @(posedge clk_i) begin
    run_start_q  <= run_start_d;
    best_start_q <= best_start_d;
    best_len_q   <= best_len_d;
  end

  assign found_o      = found_q;
  assign best_start_o = best_start_q;

endmodule

[design/fit_policy_cell_allocator_top.sv]
// ----------------------------------------------------------------------------
// fit_policy_cell_allocator_top: first/best/worst fit cell allocator
// Usage:
//   Request beats (req_type, owner_id, block_size) enter on in_valid_i /
//   in_stall_o; one result beat (status, start_cell, freed_cells) leaves on
//   out_valid_o / out_stall_i per request. Requests are handled one at a
//   time; the next request is taken while a result still waits at the output.
//   Allocate: one read pass over the owner map (one cell per cycle through
//   the single map read port), then a write pass of block_size cells
//   through the write port on success. Clear: one read-modify-write pass
//   over the map. Rejected requests (owner 0, size 0, size above NUM_CELLS)
//   skip the map and go straight to the result.
//   After reset the map is swept to zero with in_stall_o
//   high; cfg_we_i writes the fit policy at any time (0 first, 1 best,
//   2 worst, 3 acts as first) and resets to first fit.
//   While out_stall_i holds a result, a finished request waits for the
//   output register and in_stall_o stays high.
// ----------------------------------------------------------------------------
module fit_policy_cell_allocator_top #(
  parameter int unsigned NUM_CELLS = 1024
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [fpca_pkg::PolicyW-1:0]    cfg_wdata_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [fpca_pkg::TypeW-1:0]      req_type_i,
  input  logic [fpca_pkg::OwnerW-1:0]     owner_id_i,
  input  logic [fpca_pkg::SizeW-1:0]      block_size_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [fpca_pkg::StatusW-1:0]    status_o,
  output logic [fpca_pkg::StartW-1:0]     start_cell_o,
  output logic [fpca_pkg::FreedW-1:0]     freed_cells_o
);

  localparam int unsigned AddrW = $clog2(NUM_CELLS);
  localparam int unsigned CountW = AddrW + 1;
  localparam int unsigned CmpW = (CountW > fpca_pkg::SizeW) ? CountW : fpca_pkg::SizeW;
  localparam int unsigned StW = (AddrW > fpca_pkg::StartW) ? AddrW : fpca_pkg::StartW;
  localparam int unsigned FrW = (CountW > fpca_pkg::FreedW) ? CountW : fpca_pkg::FreedW;
  localparam logic [CountW-1:0] CellsC = CountW'(NUM_CELLS);
  localparam logic [CountW-1:0] LastC = CountW'(NUM_CELLS - 1);

  typedef enum logic [6:0] {
    ST_INIT = 7'b0000001,
    ST_IDLE = 7'b0000010,
    ST_SCAN = 7'b0000100,
    ST_PICK = 7'b0001000,
    ST_FILL = 7'b0010000,
    ST_CLR  = 7'b0100000,
    ST_DONE = 7'b1000000
  } state_e;

  state_e                          state_q, state_d;
  logic [fpca_pkg::PolicyW-1:0]    policy_q;
  logic [CountW-1:0]               scan_q, scan_d;
  logic                            pipe_vld_q, pipe_vld_d;
  logic [CountW-1:0]               pipe_idx_q, pipe_idx_d;
  logic                            out_vld_q, out_vld_d;

  logic [fpca_pkg::OwnerW-1:0]     owner_q, owner_d;
  logic [fpca_pkg::SizeW-1:0]      size_q, size_d;
  logic [AddrW-1:0]                fill_addr_q, fill_addr_d;
  logic [CountW-1:0]               fill_left_q, fill_left_d;
  logic [fpca_pkg::StatusW-1:0]    res_status_q, res_status_d;
  logic [AddrW-1:0]                res_start_q, res_start_d;
  logic [CountW-1:0]               res_freed_q, res_freed_d;
  logic [fpca_pkg::StatusW-1:0]    out_status_q, out_status_d;
  logic [fpca_pkg::StartW-1:0]     out_start_q, out_start_d;
  logic [fpca_pkg::FreedW-1:0]     out_freed_q, out_freed_d;

  logic                            in_acc;
  logic                            ram_we, ram_re;
  logic [AddrW-1:0]                ram_waddr;
  logic [fpca_pkg::OwnerW-1:0]     ram_wdata, ram_rdata;
  logic                            pipe_end, pipe_match;
  fpca_pkg::step_t                 step;
  logic [CountW-1:0]               need;
  logic [CmpW-1:0]                 size_ext;
  logic                            found;
  logic [AddrW-1:0]                best_start;
  logic [StW-1:0]                  start_ext;
  logic [FrW-1:0]                  freed_ext;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;

  assign size_ext   = CmpW'(size_q);
  assign need       = size_ext[CountW-1:0];
  assign pipe_end   = (pipe_idx_q == CellsC);
  assign pipe_match = pipe_vld_q && !pipe_end && (ram_rdata == owner_q);
  assign start_ext  = StW'(res_start_q);
  assign freed_ext  = FrW'(res_freed_q);

  assign step.clr  = in_acc;
  assign step.vld  = (state_q == ST_SCAN) && pipe_vld_q;
  assign step.free = !pipe_end && (ram_rdata == '0);

  // Read port: one cell per cycle during a scan or clear pass.
  assign ram_re = ((state_q == ST_SCAN) || (state_q == ST_CLR)) && (scan_q < CellsC);

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = scan_q[AddrW-1:0];
    ram_wdata = '0;
    unique case (state_q)
      ST_INIT: begin
        ram_we = 1'b1;
      end
      ST_FILL: begin
        ram_we    = 1'b1;
        ram_waddr = fill_addr_q;
        ram_wdata = owner_q;
      end
      ST_CLR: begin
        ram_we    = pipe_match;
        ram_waddr = pipe_idx_q[AddrW-1:0];
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  always_comb begin
    state_d      = state_q;
    scan_d       = scan_q;
    pipe_vld_d   = 1'b0;
    pipe_idx_d   = pipe_idx_q;
    out_vld_d    = out_vld_q && out_stall_i;
    owner_d      = owner_q;
    size_d       = size_q;
    fill_addr_d  = fill_addr_q;
    fill_left_d  = fill_left_q;
    res_status_d = res_status_q;
    res_start_d  = res_start_q;
    res_freed_d  = res_freed_q;
    out_status_d = out_status_q;
    out_start_d  = out_start_q;
    out_freed_d  = out_freed_q;

    unique case (state_q)
      ST_INIT: begin
        scan_d = scan_q + CountW'(1);
        if (scan_q == LastC) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          owner_d      = owner_id_i;
          size_d       = block_size_i;
          scan_d       = '0;
          res_status_d = fpca_pkg::STATUS_DONE;
          res_start_d  = '0;
          res_freed_d  = '0;
          priority if (owner_id_i == '0) begin
            res_status_d = fpca_pkg::STATUS_INVALID;
            state_d      = ST_DONE;
          end else if (req_type_i == fpca_pkg::REQ_CLEAR) begin
            state_d = ST_CLR;
          end else if (block_size_i == '0) begin
            res_status_d = fpca_pkg::STATUS_INVALID;
            state_d      = ST_DONE;
          end else if (CmpW'(block_size_i) > CmpW'(NUM_CELLS)) begin
            res_status_d = fpca_pkg::STATUS_NOFIT;
            state_d      = ST_DONE;
          end else begin
            state_d = ST_SCAN;
          end
        end
      end
      ST_SCAN, ST_CLR: begin
        // issue cells 0..N-1, then the end marker N
        if (scan_q <= CellsC) begin
          pipe_vld_d = 1'b1;
          pipe_idx_d = scan_q;
          scan_d     = scan_q + CountW'(1);
        end
        if (pipe_match && (state_q == ST_CLR)) begin
          res_freed_d = res_freed_q + CountW'(1);
        end
        if (pipe_vld_q && pipe_end) begin
          state_d = (state_q == ST_SCAN) ? ST_PICK : ST_DONE;
        end
      end
      ST_PICK: begin
        if (found) begin
          res_start_d = best_start;
          fill_addr_d = best_start;
          fill_left_d = need;
          state_d     = ST_FILL;
        end else begin
          res_status_d = fpca_pkg::STATUS_NOFIT;
          state_d      = ST_DONE;
        end
      end
      ST_FILL: begin
        fill_addr_d = fill_addr_q + AddrW'(1);
        fill_left_d = fill_left_q - CountW'(1);
        if (fill_left_q == CountW'(1)) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        // hold until the output register is free
        if (!out_vld_q || !out_stall_i) begin
          out_vld_d    = 1'b1;
          out_status_d = res_status_q;
          out_start_d  = start_ext[fpca_pkg::StartW-1:0];
          out_freed_d  = freed_ext[fpca_pkg::FreedW-1:0];
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_INIT;
      policy_q   <= fpca_pkg::POLICY_FIRST;
      scan_q     <= '0;
      pipe_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      scan_q     <= scan_d;
      pipe_vld_q <= pipe_vld_d;
      out_vld_q  <= out_vld_d;
      if (cfg_we_i) begin
        policy_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pipe_idx_q   <= pipe_idx_d;
    owner_q      <= owner_d;
    size_q       <= size_d;
    fill_addr_q  <= fill_addr_d;
    fill_left_q  <= fill_left_d;
    res_status_q <= res_status_d;
    res_start_q  <= res_start_d;
    res_freed_q  <= res_freed_d;
    out_status_q <= out_status_d;
    out_start_q  <= out_start_d;
    out_freed_q  <= out_freed_d;
  end

  fpca_map_ram #(
    .Depth (NUM_CELLS),
    .AddrW (AddrW),
    .DataW (fpca_pkg::OwnerW)
  ) u_map_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (scan_q[AddrW-1:0]),
    .rdata_o (ram_rdata)
  );

  fpca_run_pick #(
    .AddrW  (AddrW),
    .CountW (CountW)
  ) u_run_pick (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (step),
    .idx_i        (pipe_idx_q),
    .need_i       (need),
    .policy_i     (policy_q),
    .found_o      (found),
    .best_start_o (best_start)
  );

  assign out_valid_o   = out_vld_q;
  assign status_o      = out_status_q;
  assign start_cell_o  = out_start_q;
  assign freed_cells_o = out_freed_q;

endmodule

[sim/tb_fit_policy_cell_allocator_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_fit_policy_cell_allocator_top: self-checking bench for the cell allocator
// Keeps its own copy of the cell owner map and the fit policy, predicts one
// result per accepted request and checks every result beat field by field.
// A directed opener covers the extremes and each policy. Four random phases
// follow, one per policy code, with bursty requests and a stalling receiver.
// ----------------------------------------------------------------------------
module tb_fit_policy_cell_allocator_top;

  localparam int unsigned NUM_CELLS = 1024;
  // Code three falls back to first fit.
  localparam logic [fpca_pkg::PolicyW-1:0] POLICY_FIRST_ALIAS = 2'd3;

  logic                         clk_i;
  logic                         rst_ni;
  logic                         cfg_we_i;
  logic [fpca_pkg::PolicyW-1:0] cfg_wdata_i;
  logic                         in_valid_i;
  logic                         in_stall_o;
  logic [fpca_pkg::TypeW-1:0]   req_type_i;
  logic [fpca_pkg::OwnerW-1:0]  owner_id_i;
  logic [fpca_pkg::SizeW-1:0]   block_size_i;
  logic                         out_valid_o;
  logic                         out_stall_i;
  logic [fpca_pkg::StatusW-1:0] status_o;
  logic [fpca_pkg::StartW-1:0]  start_cell_o;
  logic [fpca_pkg::FreedW-1:0]  freed_cells_o;

  typedef struct packed {
    logic [fpca_pkg::StatusW-1:0] status;
    logic [fpca_pkg::StartW-1:0]  start_cell;
    logic [fpca_pkg::FreedW-1:0]  freed_cells;
  } grant_t;

  class alloc_scoreboard;
    logic [fpca_pkg::OwnerW-1:0]  cell_owner [NUM_CELLS];
    logic [fpca_pkg::PolicyW-1:0] policy;
    grant_t                       grants_due[$];
    int unsigned                  errors;

    function new();
      foreach (cell_owner[i]) cell_owner[i] = '0;
      policy = fpca_pkg::POLICY_FIRST;
      errors = 0;
    endfunction

    function int unsigned pending();
      return grants_due.size();
    endfunction

    // Scan one past the last cell so the trailing free run is closed too.
    function bit find_run(int unsigned need, output int unsigned where);
      bit          found;
      bit          is_free;
      int unsigned run_at;
      int unsigned run_len;
      int unsigned pick_len;
      found    = 1'b0;
      where    = 0;
      run_at   = 0;
      run_len  = 0;
      pick_len = 0;
      for (int unsigned i = 0; i <= NUM_CELLS; i++) begin
        is_free = (i < NUM_CELLS) && (cell_owner[i] == '0);
        if (is_free) begin
          if (run_len == 0) run_at = i;
          run_len++;
        end else begin
          if (run_len >= need) begin
            case (policy)
              fpca_pkg::POLICY_BEST: begin
                if (!found || run_len < pick_len) begin
                  found    = 1'b1;
                  where    = run_at;
                  pick_len = run_len;
                end
              end
              fpca_pkg::POLICY_WORST: begin
                if (!found || run_len > pick_len) begin
                  found    = 1'b1;
                  where    = run_at;
                  pick_len = run_len;
                end
              end
              default: begin
                // keep the earliest run that fits
                if (!found) begin
                  found    = 1'b1;
                  where    = run_at;
                  pick_len = run_len;
                end
              end
            endcase
          end
          run_len = 0;
        end
      end
      return found;
    endfunction

    function void take_request(logic [fpca_pkg::TypeW-1:0] kind,
                               logic [fpca_pkg::OwnerW-1:0] owner,
                               logic [fpca_pkg::SizeW-1:0] size);
      grant_t      g;
      int unsigned at;
      int unsigned freed;
      g        = '0;
      g.status = fpca_pkg::STATUS_DONE;
      at       = 0;
      freed    = 0;
      if (owner == '0) begin
        g.status = fpca_pkg::STATUS_INVALID;
      end else if (kind == fpca_pkg::REQ_CLEAR) begin
        foreach (cell_owner[i]) begin
          if (cell_owner[i] == owner) begin
            cell_owner[i] = '0;
            freed++;
          end
        end
        g.freed_cells = freed[fpca_pkg::FreedW-1:0];
      end else if (size == '0) begin
        g.status = fpca_pkg::STATUS_INVALID;
      end else if (size > NUM_CELLS || !find_run(size, at)) begin
        g.status = fpca_pkg::STATUS_NOFIT;
      end else begin
        for (int unsigned i = 0; i < size; i++) cell_owner[at + i] = owner;
        g.start_cell = at[fpca_pkg::StartW-1:0];
      end
      grants_due.push_back(g);
    endfunction

    function void check_grant(logic [fpca_pkg::StatusW-1:0] status,
                              logic [fpca_pkg::StartW-1:0] start_cell,
                              logic [fpca_pkg::FreedW-1:0] freed_cells);
      grant_t want;
      if (grants_due.size() == 0) begin
        $display("%0t: result beat with no request pending: status %0d start %0d freed %0d",
                 $time, status, start_cell, freed_cells);
        errors++;
        return;
      end
      want = grants_due.pop_front();
      if (status !== want.status) begin
        $display("%0t: status expected %0d, got %0d", $time, want.status, status);
        errors++;
      end
      if (start_cell !== want.start_cell) begin
        $display("%0t: start_cell expected %0d, got %0d", $time, want.start_cell, start_cell);
        errors++;
      end
      if (freed_cells !== want.freed_cells) begin
        $display("%0t: freed_cells expected %0d, got %0d", $time, want.freed_cells,
                 freed_cells);
        errors++;
      end
    endfunction
  endclass

  alloc_scoreboard             sb;
  int unsigned                 burst_left;
  logic [fpca_pkg::OwnerW-1:0] owner_pool [24];

  fit_policy_cell_allocator_top #(
    .NUM_CELLS(NUM_CELLS)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .req_type_i   (req_type_i),
    .owner_id_i   (owner_id_i),
    .block_size_i (block_size_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .status_o     (status_o),
    .start_cell_o (start_cell_o),
    .freed_cells_o(freed_cells_o)
  );

  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  task automatic send_request(input logic [fpca_pkg::TypeW-1:0] kind,
                              input logic [fpca_pkg::OwnerW-1:0] owner,
                              input logic [fpca_pkg::SizeW-1:0] size);
    in_valid_i   <= 1'b1;
    req_type_i   <= kind;
    owner_id_i   <= owner;
    block_size_i <= size;
    do @(posedge clk_i); while (in_stall_o);
    sb.take_request(kind, owner, size);
  endtask

  // Drain all outstanding results, then write the policy while the block idles.
  task automatic set_policy(input logic [fpca_pkg::PolicyW-1:0] code);
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= code;
    @(posedge clk_i);
    cfg_we_i  <= 1'b0;
    sb.policy  = code;
  endtask

  // Bursts of back-to-back beats separated by random gaps, some long.
  task automatic pace_sender();
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      case ($urandom_range(0, 9))
        0:       gap = 0;
        9:       gap = $urandom_range(200, 2500);
        default: gap = $urandom_range(1, 40);
      endcase
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      sb.check_grant(status_o, start_cell_o, freed_cells_o);
    end
  end

  initial begin : receiver
    int unsigned stretch;
    int unsigned mode;
    int unsigned taken;
    int unsigned next_hold;
    out_stall_i <= 1'b0;
    stretch   = 0;
    mode      = 0;
    taken     = 0;
    next_hold = 40;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) taken++;
      // Hold off long enough for the block to back up into its input.
      if (taken >= next_hold) begin
        next_hold  += 140;
        out_stall_i <= 1'b1;
        repeat (5000) @(posedge clk_i);
        stretch = 0;
      end
      if (stretch == 0) begin
        stretch = $urandom_range(20, 600);
        mode    = $urandom_range(0, 3);
      end
      stretch--;
      case (mode)
        0:       out_stall_i <= 1'b0;
        1:       out_stall_i <= ($urandom_range(0, 1) == 1);
        2:       out_stall_i <= ($urandom_range(0, 7) == 0);
        default: out_stall_i <= ($urandom_range(0, 15) != 0);
      endcase
    end
  end

  initial begin
    #30_000_000;
    $display("tb_fit_policy_cell_allocator_top: done, errors");
    $finish;
  end

  initial begin
    logic [fpca_pkg::TypeW-1:0]   kind;
    logic [fpca_pkg::OwnerW-1:0]  owner;
    logic [fpca_pkg::SizeW-1:0]   size;
    logic [fpca_pkg::PolicyW-1:0] code;
    int unsigned                  pick;
    int unsigned                  roll;
    sb            = new();
    burst_left    = 0;
    rst_ni       <= 1'b0;
    cfg_we_i     <= 1'b0;
    cfg_wdata_i  <= '0;
    in_valid_i   <= 1'b0;
    req_type_i   <= fpca_pkg::REQ_ALLOC;
    owner_id_i   <= '0;
    block_size_i <= '0;

    for (int k = 0; k < 8; k++) owner_pool[k] = fpca_pkg::OwnerW'(k + 1);
    for (int k = 0; k < 10; k++) owner_pool[8 + k] = fpca_pkg::OwnerW'(16'h0010 + k);
    owner_pool[18] = 16'hFFFF;
    owner_pool[19] = 16'h8000;
    for (int k = 20; k < 24; k++) owner_pool[k] = fpca_pkg::OwnerW'($urandom_range(1, 65535));

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Rejects, oversize, a full-map fill and the clears around it.
    set_policy(fpca_pkg::POLICY_FIRST);
    send_request(fpca_pkg::REQ_ALLOC, 16'h0000, 11'd5);
    send_request(fpca_pkg::REQ_CLEAR, 16'h0000, 11'd0);
    send_request(fpca_pkg::REQ_ALLOC, 16'h0001, 11'd0);
    send_request(fpca_pkg::REQ_ALLOC, 16'hFFFF, 11'h7FF);
    send_request(fpca_pkg::REQ_ALLOC, 16'h8000, 11'd1025);
    send_request(fpca_pkg::REQ_ALLOC, 16'h0002, 11'd1024);
    send_request(fpca_pkg::REQ_ALLOC, 16'h0003, 11'd1);
    send_request(fpca_pkg::REQ_CLEAR, 16'h0002, 11'h7FF);
    send_request(fpca_pkg::REQ_CLEAR, 16'h0005, 11'd0);

    // Fragment the map: free runs of 50, 30 and a trailing 334.
    send_request(fpca_pkg::REQ_ALLOC, 16'h0010, 11'd100);
    send_request(fpca_pkg::REQ_ALLOC, 16'h0011, 11'd50);
    send_request(fpca_pkg::REQ_ALLOC, 16'h0012, 11'd200);
    send_request(fpca_pkg::REQ_ALLOC, 16'h0013, 11'd30);
    send_request(fpca_pkg::REQ_ALLOC, 16'hFFFF, 11'd300);
    send_request(fpca_pkg::REQ_ALLOC, 16'h0014, 11'd10);
    send_request(fpca_pkg::REQ_CLEAR, 16'h0011, 11'd0);
    send_request(fpca_pkg::REQ_CLEAR, 16'h0013, 11'd0);

    set_policy(fpca_pkg::POLICY_BEST);
    send_request(fpca_pkg::REQ_ALLOC, 16'h0015, 11'd25);
    set_policy(fpca_pkg::POLICY_WORST);
    send_request(fpca_pkg::REQ_ALLOC, 16'h0016, 11'd20);
    send_request(fpca_pkg::REQ_ALLOC, 16'h0017, 11'd400);
    set_policy(POLICY_FIRST_ALIAS);
    send_request(fpca_pkg::REQ_ALLOC, 16'h0018, 11'd40);
    set_policy(fpca_pkg::POLICY_BEST);
    send_request(fpca_pkg::REQ_ALLOC, 16'h0019, 11'd5);

    for (int p = 0; p < 4; p++) begin
      case (p)
        0:       code = fpca_pkg::POLICY_BEST;
        1:       code = fpca_pkg::POLICY_WORST;
        2:       code = POLICY_FIRST_ALIAS;
        default: code = fpca_pkg::POLICY_FIRST;
      endcase
      set_policy(code);
      for (int n = 0; n < 72; n++) begin
        pace_sender();
        roll = $urandom_range(0, 19);
        if (roll == 0)     size = '0;
        else if (roll == 1) size = fpca_pkg::SizeW'($urandom_range(1025, 2047));
        else if (roll < 4)  size = fpca_pkg::SizeW'($urandom_range(65, 1024));
        else                size = fpca_pkg::SizeW'($urandom_range(1, 64));
        owner = owner_pool[$urandom_range(0, 23)];
        pick  = $urandom_range(0, 99);
        if (pick < 62) begin
          kind = fpca_pkg::REQ_ALLOC;
        end else if (pick < 90) begin
          kind = fpca_pkg::REQ_CLEAR;
        end else if (pick < 95) begin
          kind  = fpca_pkg::TypeW'($urandom_range(0, 1));
          owner = '0;
        end else begin
          kind  = fpca_pkg::REQ_CLEAR;
          owner = fpca_pkg::OwnerW'($urandom_range(0, 65535));
        end
        send_request(kind, owner, size);
      end
    end

    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    // Catch any stray beat after the last expected one.
    repeat (2200) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb_fit_policy_cell_allocator_top: done, clean");
    end else begin
      $display("tb_fit_policy_cell_allocator_top: done, errors");
    end
    $finish;
  end

endmodule
